[src/polygon_edge_clipper_assert.svh]
// assertion macros shared by the clipper rtl files
// expects clk and arst_n in the scope of every use
`ifndef POLYGON_EDGE_CLIPPER_ASSERT_SVH
`define POLYGON_EDGE_CLIPPER_ASSERT_SVH
`ifndef SYNTHESIS
`define PEC_ASSERT(label, expr) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error("pec assertion failed");
`define PEC_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("pec implication failed");
`define PEC_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("pec next-cycle check failed");
`else
`define PEC_ASSERT(label, expr)
`define PEC_ASSERT_IMPL(label, ante, cons)
`define PEC_ASSERT_NEXT(label, ante, cons)
`endif
`endif

[src/pec_pkg.sv]
// shared types and constants of the polygon edge clipper
// no dependencies; used by every rtl module of the block except pec_div
`default_nettype none

package pec_pkg;

	localparam int COORD_BITS_DEF = 12;

	// vertex counter on the end marker, saturating
	localparam int CNT_W = 7;
	localparam logic [CNT_W-1:0] CNT_MAX = '1;

	// register reset values
	localparam int X_MIN_RST = 200;
	localparam int X_MAX_RST = 500;
	localparam int Y_MIN_RST = 100;
	localparam int Y_MAX_RST = 350;

	// configuration register indexes
	localparam int REG_IDX_W = 3;
	localparam logic [REG_IDX_W-1:0] REG_X_MIN    = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_X_MAX    = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_Y_MIN    = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_Y_MAX    = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_BOUNDARY = 3'd4;

	// boundary codes
	localparam logic [1:0] BND_LEFT   = 2'd0;
	localparam logic [1:0] BND_RIGHT  = 2'd1;
	localparam logic [1:0] BND_TOP    = 2'd2;
	localparam logic [1:0] BND_BOTTOM = 2'd3;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_EDGE,
		ST_MUL_A,
		ST_MUL_B,
		ST_SUM,
		ST_DIV_GO,
		ST_DIV_WAIT,
		ST_EMIT_X,
		ST_EMIT_V,
		ST_CLOSE,
		ST_EMIT_END
	} pec_state_t;

	typedef struct packed {
		logic take;
		logic load_close;
		logic mul_a;
		logic mul_b;
		logic sum;
		logic div_start;
		logic emit_isect;
		logic emit_vtx;
		logic emit_end;
		logic run_last;
	} pec_cmd_t;

	typedef struct packed {
		logic have_first;
		logic item_last;
		logic in_a;
		logic in_c;
		logic div_busy;
		logic out_free;
	} pec_stat_t;

endpackage

`default_nettype wire

[src/pec_div.sv]
// signed shift-subtract divider, one quotient bit per cycle, truncates toward zero
// depends on the assertion header only
`default_nettype none
`include "polygon_edge_clipper_assert.svh"

module pec_div #(
	parameter int NW = 27,
	parameter int DW = 13,
	parameter int QW = 12
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic signed [NW-1:0] num,
	input  logic signed [DW-1:0] den,
	output logic                 busy,
	output logic signed [QW-1:0] quo
);

	localparam int CW = $clog2(QW + 1);

	logic [NW-1:0] rem_q;
	logic [NW-1:0] dsh_q;
	logic [QW-1:0] q_q;
	logic          neg_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic [NW-1:0] num_mag;
	logic [DW-1:0] den_mag;
	logic          ge;

	assign num_mag = num[NW-1] ? (~num + 1'b1) : num;
	assign den_mag = den[DW-1] ? (~den + 1'b1) : den;
	assign ge      = rem_q >= dsh_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CW'(QW);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CW'(1))
				busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= num_mag;
			dsh_q <= NW'(den_mag) << (QW - 1);
			q_q   <= '0;
			neg_q <= num[NW-1] ^ den[DW-1];
		end else if (busy_q) begin
			if (ge)
				rem_q <= rem_q - dsh_q;
			q_q   <= {q_q[QW-2:0], ge};
			dsh_q <= dsh_q >> 1;
		end
	end

	assign busy = busy_q;
	assign quo  = neg_q ? (~q_q + 1'b1) : q_q;

	`PEC_ASSERT(a_div_no_restart, !(start && busy_q))
	`PEC_ASSERT_IMPL(a_div_cnt_live, busy_q, cnt_q != '0)

endmodule

`default_nettype wire

[src/pec_datapath.sv]
// clipper datapath: window registers, vertex registers, shared multiplier,
// divider and output register; depends on pec_pkg and pec_div
`default_nettype none
`include "polygon_edge_clipper_assert.svh"

module pec_datapath #(
	parameter int COORD_BITS = pec_pkg::COORD_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [pec_pkg::REG_IDX_W-1:0]      cfg_index,
	input  logic [COORD_BITS-1:0]              cfg_data,
	input  logic signed [COORD_BITS-1:0]       in_x,
	input  logic signed [COORD_BITS-1:0]       in_y,
	input  logic                               in_last,
	input  pec_pkg::pec_cmd_t                  cmd,
	output pec_pkg::pec_stat_t                 stat,
	output logic [COORD_BITS-1:0]              out_x,
	output logic [COORD_BITS-1:0]              out_y,
	output logic                               out_end,
	output logic [pec_pkg::CNT_W-1:0]          out_cnt,
	output logic                               out_last,
	output logic                               out_valid,
	input  logic                               out_ready
);

	import pec_pkg::*;

	localparam int C  = COORD_BITS;
	localparam int DW = C + 1;
	localparam int PW = 2 * C + 2;
	localparam int NW = 2 * C + 3;

	logic signed [C-1:0]  xmin_q, xmax_q, ymin_q, ymax_q;
	logic [1:0]           bnd_q;
	logic signed [C-1:0]  first_x_q, first_y_q, prev_x_q, prev_y_q;
	logic signed [C-1:0]  e1x_q, e1y_q, e2x_q, e2y_q;
	logic                 have_first_q, last_q;
	logic signed [PW-1:0] pa_q, pb_q;
	logic signed [NW-1:0] num_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [C-1:0]         ox_q, oy_q;
	logic                 oend_q, olast_q, ov_q;
	logic [CNT_W-1:0]     ocnt_q;

	logic                 in_a, in_c, horiz, den_zero, div_busy, any_emit;
	logic signed [C-1:0]  bnd_val, u1, v1, u2, v2, div_quo, isect_v, ix, iy;
	logic signed [DW-1:0] den, du, dv, ma, mb;
	logic signed [PW-1:0] prod;

	// inside tests of both edge endpoints against the selected boundary
	always_comb begin
		case (bnd_q)
			BND_LEFT: begin
				in_a    = e1x_q >= xmin_q;
				in_c    = e2x_q >= xmin_q;
				bnd_val = xmin_q;
			end
			BND_RIGHT: begin
				in_a    = e1x_q <= xmax_q;
				in_c    = e2x_q <= xmax_q;
				bnd_val = xmax_q;
			end
			BND_TOP: begin
				in_a    = e1y_q <= ymax_q;
				in_c    = e2y_q <= ymax_q;
				bnd_val = ymax_q;
			end
			default: begin
				// bottom
				in_a    = e1y_q >= ymin_q;
				in_c    = e2y_q >= ymin_q;
				bnd_val = ymin_q;
			end
		endcase
	end

	// u runs across the boundary, v along it
	assign horiz = (bnd_q == BND_LEFT) || (bnd_q == BND_RIGHT);
	assign u1    = horiz ? e1x_q : e1y_q;
	assign v1    = horiz ? e1y_q : e1x_q;
	assign u2    = horiz ? e2x_q : e2y_q;
	assign v2    = horiz ? e2y_q : e2x_q;

	assign den = DW'(u2) - DW'(u1);
	assign du  = DW'(bnd_val) - DW'(u1);
	assign dv  = DW'(v2) - DW'(v1);

	// one multiplier: v1*den first, then dv*du
	assign ma   = cmd.mul_b ? dv : DW'(v1);
	assign mb   = cmd.mul_b ? du : den;
	assign prod = ma * mb;

	always_ff @(posedge clk) begin
		if (cmd.mul_a)
			pa_q <= prod;
		if (cmd.mul_b)
			pb_q <= prod;
		if (cmd.sum)
			num_q <= NW'(pa_q) + NW'(pb_q);
	end

	pec_div #(
		.NW(NW),
		.DW(DW),
		.QW(C)
	) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (cmd.div_start),
		.num   (num_q),
		.den   (den),
		.busy  (div_busy),
		.quo   (div_quo)
	);

	assign den_zero = den == '0;
	assign isect_v  = den_zero ? v1 : div_quo;
	assign ix       = horiz ? bnd_val : isect_v;
	assign iy       = horiz ? isect_v : bnd_val;

	// window registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			xmin_q <= C'(X_MIN_RST);
			xmax_q <= C'(X_MAX_RST);
			ymin_q <= C'(Y_MIN_RST);
			ymax_q <= C'(Y_MAX_RST);
			bnd_q  <= BND_LEFT;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_X_MIN:    xmin_q <= cfg_data;
				REG_X_MAX:    xmax_q <= cfg_data;
				REG_Y_MIN:    ymin_q <= cfg_data;
				REG_Y_MAX:    ymax_q <= cfg_data;
				REG_BOUNDARY: bnd_q  <= cfg_data[1:0];
				default: ;
			endcase
		end
	end

	// vertex registers
	always_ff @(posedge clk) begin
		if (cmd.take) begin
			e1x_q    <= have_first_q ? prev_x_q : in_x;
			e1y_q    <= have_first_q ? prev_y_q : in_y;
			e2x_q    <= in_x;
			e2y_q    <= in_y;
			prev_x_q <= in_x;
			prev_y_q <= in_y;
			last_q   <= in_last;
			if (!have_first_q) begin
				first_x_q <= in_x;
				first_y_q <= in_y;
			end
		end else if (cmd.load_close) begin
			e1x_q <= e2x_q;
			e1y_q <= e2y_q;
			e2x_q <= first_x_q;
			e2y_q <= first_y_q;
		end
	end

	assign any_emit = cmd.emit_isect || cmd.emit_vtx || cmd.emit_end;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_first_q <= 1'b0;
			cnt_q        <= '0;
			ov_q         <= 1'b0;
		end else begin
			if (cmd.take)
				have_first_q <= 1'b1;
			else if (cmd.emit_end)
				have_first_q <= 1'b0;
			if (cmd.emit_end)
				cnt_q <= '0;
			else if ((cmd.emit_isect || cmd.emit_vtx) && cnt_q != CNT_MAX)
				cnt_q <= cnt_q + 1'b1;
			if (any_emit)
				ov_q <= 1'b1;
			else if (out_ready)
				ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_isect) begin
			ox_q    <= ix;
			oy_q    <= iy;
			oend_q  <= 1'b0;
			ocnt_q  <= '0;
			olast_q <= cmd.run_last;
		end else if (cmd.emit_vtx) begin
			ox_q    <= e2x_q;
			oy_q    <= e2y_q;
			oend_q  <= 1'b0;
			ocnt_q  <= '0;
			olast_q <= cmd.run_last;
		end else if (cmd.emit_end) begin
			ox_q    <= '0;
			oy_q    <= '0;
			oend_q  <= 1'b1;
			ocnt_q  <= cnt_q;
			olast_q <= 1'b1;
		end
	end

	assign stat.have_first = have_first_q;
	assign stat.item_last  = last_q;
	assign stat.in_a       = in_a;
	assign stat.in_c       = in_c;
	assign stat.div_busy   = div_busy;
	assign stat.out_free   = !ov_q || out_ready;

	assign out_x     = ox_q;
	assign out_y     = oy_q;
	assign out_end   = oend_q;
	assign out_cnt   = ocnt_q;
	assign out_last  = olast_q;
	assign out_valid = ov_q;

	`PEC_ASSERT_IMPL(a_isect_nonzero_den, cmd.emit_isect, !den_zero)
	`PEC_ASSERT_IMPL(a_emit_has_room, any_emit, !ov_q || out_ready)

endmodule

`default_nettype wire

[src/pec_ctrl.sv]
// clipper controller: walks each vertex through edge test, intersection and emits
// depends on pec_pkg
`default_nettype none
`include "polygon_edge_clipper_assert.svh"

module pec_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_last,
	output logic               in_ready,
	input  pec_pkg::pec_stat_t stat,
	output pec_pkg::pec_cmd_t  cmd
);

	import pec_pkg::*;

	pec_state_t state_q, state_nxt, done_nxt;
	logic       closing_q;

	// where to go once the current edge has produced its results
	assign done_nxt = closing_q ? ST_EMIT_END : (stat.item_last ? ST_CLOSE : ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			closing_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (state_q == ST_CLOSE)
				closing_q <= 1'b1;
			else if (state_q == ST_EMIT_END && stat.out_free)
				closing_q <= 1'b0;
		end
	end

	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		in_ready  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.take = 1'b1;
					// first vertex of a polygon forms no edge
					if (stat.have_first)
						state_nxt = ST_EDGE;
					else if (in_last)
						state_nxt = ST_CLOSE;
				end
			end
			ST_EDGE: begin
				if (stat.in_a && stat.in_c)
					state_nxt = ST_EMIT_V;
				else if (stat.in_a || stat.in_c)
					state_nxt = ST_MUL_A;
				else
					state_nxt = done_nxt;
			end
			ST_MUL_A: begin
				cmd.mul_a = 1'b1;
				state_nxt = ST_MUL_B;
			end
			ST_MUL_B: begin
				cmd.mul_b = 1'b1;
				state_nxt = ST_SUM;
			end
			ST_SUM: begin
				cmd.sum   = 1'b1;
				state_nxt = ST_DIV_GO;
			end
			ST_DIV_GO: begin
				cmd.div_start = 1'b1;
				state_nxt     = ST_DIV_WAIT;
			end
			ST_DIV_WAIT: begin
				if (!stat.div_busy)
					state_nxt = ST_EMIT_X;
			end
			ST_EMIT_X: begin
				if (stat.out_free) begin
					cmd.emit_isect = 1'b1;
					// exit crossing ends the item's results unless a close follows
					cmd.run_last   = !stat.item_last && !stat.in_c;
					state_nxt      = stat.in_c ? ST_EMIT_V : done_nxt;
				end
			end
			ST_EMIT_V: begin
				if (stat.out_free) begin
					cmd.emit_vtx = 1'b1;
					cmd.run_last = !stat.item_last;
					state_nxt    = done_nxt;
				end
			end
			ST_CLOSE: begin
				cmd.load_close = 1'b1;
				state_nxt      = ST_EDGE;
			end
			ST_EMIT_END: begin
				if (stat.out_free) begin
					cmd.emit_end = 1'b1;
					state_nxt    = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	`PEC_ASSERT_NEXT(a_div_launch, state_q == ST_DIV_GO, stat.div_busy)
	`PEC_ASSERT_IMPL(a_close_only_last, closing_q, stat.item_last)

endmodule

`default_nettype wire

[src/polygon_edge_clipper.sv]
// top level of the polygon edge clipper: one boundary pass over a vertex stream
// depends on pec_pkg, pec_ctrl, pec_datapath, pec_div
//
// channel   | direction | handshake                    | payload
// s_axis    | in        | s_axis_tvalid/s_axis_tready  | vertex, tlast marks final vertex
// m_axis    | out       | m_axis_tvalid/m_axis_tready  | clipped vertex or end marker
// cfg       | in        | cfg_valid/cfg_ready          | register index and data
//
// a first vertex is only stored; an edge with no crossing passes the edge test, then an
// endpoint emit when both ends are inside; a crossing edge adds two multiplies, a sum and
// the shift-subtract divider that retires one quotient bit per cycle before its crossing emit
// and any endpoint emit; the final vertex adds a step to load the closing edge, that edge's
// steps and the end marker emit
// reset is asynchronous and needs no clearing pass; a stalled output holds the
// controller at its next emit, while a new vertex is taken with a result still waiting
`default_nettype none

module polygon_edge_clipper #(
	parameter int  COORD_BITS = pec_pkg::COORD_BITS_DEF,
	localparam int IN_W       = ((2 * COORD_BITS + 7) / 8) * 8,
	localparam int OUT_W      = ((2 * COORD_BITS + pec_pkg::CNT_W + 7) / 8) * 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	input  logic [IN_W-1:0]               s_axis_tdata,  // vertex_x, vertex_y
	input  logic                          s_axis_tlast,  // is_last
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	output logic [OUT_W-1:0]              m_axis_tdata,  // out_x, out_y, vertex_count
	output logic                          m_axis_tuser,  // is_end_marker
	output logic                          m_axis_tlast,  // run_last
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [pec_pkg::REG_IDX_W-1:0] cfg_index,
	input  logic [COORD_BITS-1:0]         cfg_data
);

	import pec_pkg::*;

	pec_cmd_t                cmd;
	pec_stat_t               stat;
	logic [COORD_BITS-1:0]   out_x, out_y;
	logic [CNT_W-1:0]        out_cnt;

	assign cfg_ready = 1'b1;

	pec_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(s_axis_tvalid),
		.in_last (s_axis_tlast),
		.in_ready(s_axis_tready),
		.stat    (stat),
		.cmd     (cmd)
	);

	pec_datapath #(
		.COORD_BITS(COORD_BITS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_valid && cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.in_x     (s_axis_tdata[COORD_BITS-1:0]),
		.in_y     (s_axis_tdata[2*COORD_BITS-1:COORD_BITS]),
		.in_last  (s_axis_tlast),
		.cmd      (cmd),
		.stat     (stat),
		.out_x    (out_x),
		.out_y    (out_y),
		.out_end  (m_axis_tuser),
		.out_cnt  (out_cnt),
		.out_last (m_axis_tlast),
		.out_valid(m_axis_tvalid),
		.out_ready(m_axis_tready)
	);

	assign m_axis_tdata = OUT_W'({out_cnt, out_y, out_x});

endmodule

`default_nettype wire
